/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("concurrent assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TLG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("concurrent assertion failed");

`endif

/* design/tlg_pkg.sv */
// ----------------------------------------------------------------------------
// tlg_pkg
// Field widths, codes and rule constants of the toroidal Life grid.
// ----------------------------------------------------------------------------
package tlg_pkg;

	localparam int unsigned ACTION_W    = 2;
	localparam int unsigned COORD_W     = 6;
	localparam int unsigned DIM_REG_W   = 7;
	localparam int unsigned COUNT_W     = 4;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned MAX_DIM_DEF = 64;

	localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd50;

	// Life rule: birth on three neighbors, survival on two (or three).
	localparam logic [COUNT_W-1:0] BIRTH_COUNT   = 4'd3;
	localparam logic [COUNT_W-1:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE   = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_READ    = 2'd2
	} action_t;

	localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 1'b1;

endpackage

/* design/tlg_if.sv */
// ----------------------------------------------------------------------------
// tlg_if
// Valid/ready channels carrying grid requests and their results.
// ----------------------------------------------------------------------------
interface tlg_in_if;
	import tlg_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [COORD_W-1:0]  column;
	logic [COORD_W-1:0]  row_index;
	logic                alive_in;

	modport source (output valid, action, column, row_index, alive_in, input ready);
	modport sink (input valid, action, column, row_index, alive_in, output ready);
endinterface

interface tlg_out_if;
	import tlg_pkg::*;

	logic               valid;
	logic               ready;
	logic               alive_out;
	logic [COUNT_W-1:0] neighbour_count;

	modport source (output valid, alive_out, neighbour_count, input ready);
	modport sink (input valid, alive_out, neighbour_count, output ready);
endinterface

/* design/toroidal_life_grid_unit.sv */
// ----------------------------------------------------------------------------
// toroidal_life_grid_unit
// Life grid with wrapped edges, held in two row-wide synchronous memories.
// ----------------------------------------------------------------------------
// The grid is stored one row per memory word: an alive memory of MAX_DIM bits
// per row and a count memory of four bits per cell. A request writes a cell,
// reads a cell, or advances the whole grid by one generation, and every
// request returns exactly one result. Writes and reads pass from acceptance
// through the memory read, the access state and the done state to a result in
// the output register. An advance is paced by the alive memory's single read
// port, which streams one row per cycle into a three-row window, while the
// count memory is read and both memories are written one row behind.
// Reset leaves the memories untouched; a valid flag per row makes rows that
// were never written read as dead cells with zero counts, so no clearing pass
// is needed and requests are taken right after reset. A new request is taken
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module toroidal_life_grid_unit #(
	parameter int unsigned MAX_DIM = tlg_pkg::MAX_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tlg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tlg_pkg::DIM_REG_W-1:0]     cfg_data,
	tlg_in_if.sink                            request,
	tlg_out_if.source                         result
);
	import tlg_pkg::*;

	localparam int unsigned RW        = $clog2(MAX_DIM);
	localparam int unsigned DW        = $clog2(MAX_DIM + 1);
	localparam int unsigned SW        = $clog2(MAX_DIM + 2);
	localparam int unsigned CMP_W     = (SW > DIM_REG_W) ? SW : DIM_REG_W;
	localparam int unsigned CNT_ROW_W = COUNT_W * MAX_DIM;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ACCESS = 4'b0010,
		S_GEN    = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q;

	// Configuration registers keep the written bits; clamping happens below.
	logic [DIM_REG_W-1:0] width_reg_q;
	logic [DIM_REG_W-1:0] height_reg_q;
	logic [CMP_W-1:0]     w_ext;
	logic [CMP_W-1:0]     h_ext;
	logic [CMP_W-1:0]     h_plus1;

	// Request fields held while the request is worked on.
	logic [ACTION_W-1:0]  act_q;
	logic [RW-1:0]        col_q;
	logic                 alive_in_q;
	logic                 inside_q;
	logic [RW-1:0]        row_q;

	logic [CMP_W-1:0]     req_col_ext;
	logic [CMP_W-1:0]     req_row_ext;
	logic                 req_inside;
	logic                 req_accept;

	// Memories and their row valid flags.
	logic [MAX_DIM-1:0]   alive_mem [MAX_DIM];
	logic [CNT_ROW_W-1:0] count_mem [MAX_DIM];
	logic [MAX_DIM-1:0]   alive_vld_q;
	logic [MAX_DIM-1:0]   count_vld_q;

	logic                 alive_rd_en;
	logic [RW-1:0]        alive_rd_addr;
	logic [MAX_DIM-1:0]   alive_rdata_q;
	logic                 alive_rvld_q;
	logic                 alive_wr_en;
	logic [RW-1:0]        alive_wr_addr;
	logic [MAX_DIM-1:0]   alive_wr_data;

	logic                 count_rd_en;
	logic [RW-1:0]        count_rd_addr;
	logic [CNT_ROW_W-1:0] count_rdata_q;
	logic                 count_rvld_q;
	logic                 count_wr_en;

	logic [MAX_DIM-1:0]   alive_row;
	logic [CNT_ROW_W-1:0] count_row;
	logic [MAX_DIM-1:0]   cell_wr_row;

	// Generation sweep.
	logic                 gen_run_q;
	logic [SW-1:0]        step_q;
	logic [CMP_W-1:0]     step_ext;
	logic [CMP_W-1:0]     gen_rd_full;
	logic                 s1_v_q;
	logic [SW-1:0]        s1_step_q;
	logic [CMP_W-1:0]     s1_step_ext;
	logic [CMP_W-1:0]     s1_row_full;
	logic                 s1_saved;
	logic [MAX_DIM-1:0]   s1_in_row;
	logic                 s2_v_q;
	logic [RW-1:0]        s2_row_q;
	logic                 gen_last;
	logic [MAX_DIM-1:0]   row0_q;
	logic [MAX_DIM-1:0]   win_prev_q;
	logic [MAX_DIM-1:0]   win_cur_q;
	logic [MAX_DIM-1:0]   win_next_q;
	logic [MAX_DIM-1:0]   calc_alive;
	logic [CNT_ROW_W-1:0] calc_count;

	// Result staging and output register.
	logic                 res_alive_q;
	logic [COUNT_W-1:0]   res_count_q;
	logic                 out_valid_q;
	logic                 out_alive_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic                 out_load;

	// A width or height of zero acts as one, and anything above MAX_DIM as MAX_DIM.
	always_comb begin
		w_ext = CMP_W'(width_reg_q);
		if (width_reg_q == '0) begin
			w_ext = CMP_W'(1);
		end else if (w_ext > CMP_W'(MAX_DIM)) begin
			w_ext = CMP_W'(MAX_DIM);
		end
		h_ext = CMP_W'(height_reg_q);
		if (height_reg_q == '0) begin
			h_ext = CMP_W'(1);
		end else if (h_ext > CMP_W'(MAX_DIM)) begin
			h_ext = CMP_W'(MAX_DIM);
		end
	end

	assign h_plus1 = h_ext + CMP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg_q  <= DIM_RESET;
			height_reg_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_reg_q  <= cfg_data;
				CFG_HEIGHT: height_reg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request side: one request is worked on at a time.
	assign request.ready = (state_q == S_IDLE);
	assign req_accept    = request.valid && request.ready;
	assign req_col_ext   = CMP_W'(request.column);
	assign req_row_ext   = CMP_W'(request.row_index);
	assign req_inside    = (req_col_ext < w_ext) && (req_row_ext < h_ext);

	always_ff @(posedge clk) begin
		if (req_accept) begin
			act_q      <= request.action;
			col_q      <= req_col_ext[RW-1:0];
			row_q      <= req_row_ext[RW-1:0];
			alive_in_q <= request.alive_in;
			inside_q   <= req_inside;
		end
	end

	// Rows never written since reset read as all zero.
	assign alive_row = alive_rvld_q ? alive_rdata_q : '0;
	assign count_row = count_rvld_q ? count_rdata_q : '0;

	always_comb begin
		cell_wr_row        = alive_row;
		cell_wr_row[col_q] = alive_in_q;
	end

	// The sweep reads row height-1 first, then rows 0 to height-1. The last
	// step reads nothing and feeds the saved copy of the old row 0, which the
	// sweep has already overwritten by then.
	assign step_ext    = CMP_W'(step_q);
	assign gen_rd_full = (step_q == '0) ? (h_ext - CMP_W'(1)) : (step_ext - CMP_W'(1));
	assign s1_step_ext = CMP_W'(s1_step_q);
	assign s1_row_full = s1_step_ext - CMP_W'(2);
	assign s1_saved    = (s1_step_ext == h_plus1);
	assign s1_in_row   = s1_saved ? row0_q : alive_row;
	assign gen_last    = s2_v_q && (CMP_W'(s2_row_q) == (h_ext - CMP_W'(1)));

	// Memory port selection. Within a sweep, row k is written only after the
	// last read of row k, so no forwarding is needed.
	always_comb begin
		alive_rd_en   = 1'b0;
		alive_rd_addr = req_row_ext[RW-1:0];
		count_rd_en   = 1'b0;
		count_rd_addr = req_row_ext[RW-1:0];
		if (req_accept) begin
			alive_rd_en = 1'b1;
			count_rd_en = 1'b1;
		end else begin
			if (gen_run_q && (step_ext <= h_ext)) begin
				alive_rd_en   = 1'b1;
				alive_rd_addr = gen_rd_full[RW-1:0];
			end
			if (s1_v_q && (s1_step_ext >= CMP_W'(2))) begin
				count_rd_en   = 1'b1;
				count_rd_addr = s1_row_full[RW-1:0];
			end
		end
	end

	always_comb begin
		alive_wr_en   = 1'b0;
		alive_wr_addr = row_q;
		alive_wr_data = cell_wr_row;
		count_wr_en   = 1'b0;
		if (s2_v_q) begin
			alive_wr_en   = 1'b1;
			alive_wr_addr = s2_row_q;
			alive_wr_data = calc_alive;
			count_wr_en   = 1'b1;
		end else if ((state_q == S_ACCESS) && (act_q == ACT_WRITE) && inside_q) begin
			alive_wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (alive_wr_en) begin
			alive_mem[alive_wr_addr] <= alive_wr_data;
		end
		if (alive_rd_en) begin
			alive_rdata_q <= alive_mem[alive_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (count_wr_en) begin
			count_mem[s2_row_q] <= calc_count;
		end
		if (count_rd_en) begin
			count_rdata_q <= count_mem[count_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_vld_q  <= '0;
			count_vld_q  <= '0;
			alive_rvld_q <= 1'b0;
			count_rvld_q <= 1'b0;
		end else begin
			if (alive_wr_en) begin
				alive_vld_q[alive_wr_addr] <= 1'b1;
			end
			if (count_wr_en) begin
				count_vld_q[s2_row_q] <= 1'b1;
			end
			if (alive_rd_en) begin
				alive_rvld_q <= alive_vld_q[alive_rd_addr];
			end
			if (count_rd_en) begin
				count_rvld_q <= count_vld_q[count_rd_addr];
			end
		end
	end

	// Sweep window: once three rows are in, each cycle finishes one row.
	always_ff @(posedge clk) begin
		if (s1_v_q) begin
			win_prev_q <= win_cur_q;
			win_cur_q  <= win_next_q;
			win_next_q <= s1_in_row;
			s2_row_q   <= s1_row_full[RW-1:0];
			if (s1_step_q == SW'(1)) begin
				row0_q <= alive_row;
			end
		end
		s1_step_q <= step_q;
	end

	tlg_row_calc #(
		.MAX_DIM (MAX_DIM)
	) u_row_calc (
		.act_width (w_ext[DW-1:0]),
		.prev_row  (win_prev_q),
		.cur_row   (win_cur_q),
		.next_row  (win_next_q),
		.old_count (count_row),
		.new_alive (calc_alive),
		.new_count (calc_count)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			gen_run_q   <= 1'b0;
			step_q      <= '0;
			s1_v_q      <= 1'b0;
			s2_v_q      <= 1'b0;
			res_alive_q <= 1'b0;
			res_count_q <= '0;
		end else begin
			s1_v_q <= gen_run_q;
			s2_v_q <= s1_v_q && (s1_step_ext >= CMP_W'(2));
			if (gen_run_q) begin
				step_q <= step_q + SW'(1);
				if (step_ext == h_plus1) begin
					gen_run_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						state_q <= S_ACCESS;
					end
				end
				S_ACCESS: begin
					res_alive_q <= 1'b0;
					res_count_q <= '0;
					state_q     <= S_DONE;
					unique case (act_q)
						ACT_READ: begin
							if (inside_q) begin
								res_alive_q <= alive_row[col_q];
								res_count_q <= count_row[col_q*COUNT_W +: COUNT_W];
							end
						end
						ACT_ADVANCE: begin
							gen_run_q <= 1'b1;
							step_q    <= '0;
							state_q   <= S_GEN;
						end
						default: ;
					endcase
				end
				S_GEN: begin
					if (gen_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: holds one result while the next request is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_alive_q <= res_alive_q;
			out_count_q <= res_count_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.alive_out       = out_alive_q;
	assign result.neighbour_count = out_count_q;

endmodule

/* design/tlg_row_calc.sv */
// ----------------------------------------------------------------------------
// tlg_row_calc
// Computes the neighbor counts and next alive bits of one grid row.
// ----------------------------------------------------------------------------
module tlg_row_calc #(
	parameter int unsigned MAX_DIM = tlg_pkg::MAX_DIM_DEF
) (
	input  logic [$clog2(MAX_DIM+1)-1:0]          act_width,
	input  logic [MAX_DIM-1:0]                    prev_row,
	input  logic [MAX_DIM-1:0]                    cur_row,
	input  logic [MAX_DIM-1:0]                    next_row,
	input  logic [tlg_pkg::COUNT_W*MAX_DIM-1:0]   old_count,
	output logic [MAX_DIM-1:0]                    new_alive,
	output logic [tlg_pkg::COUNT_W*MAX_DIM-1:0]   new_count
);
	import tlg_pkg::*;

	localparam int unsigned DW = $clog2(MAX_DIM+1);
	localparam int unsigned RW = $clog2(MAX_DIM);

	logic [RW-1:0] last_col;
	logic          prev_wrap;
	logic          cur_wrap;
	logic          next_wrap;

	// The left neighbor of column zero is the last active column.
	assign last_col  = RW'(act_width - DW'(1));
	assign prev_wrap = prev_row[last_col];
	assign cur_wrap  = cur_row[last_col];
	assign next_wrap = next_row[last_col];

	for (genvar c = 0; c < MAX_DIM; c++) begin : g_lane
		logic               pl, pr, cl, cr, nl, nr;
		logic               active;
		logic [COUNT_W-1:0] total;

		if (c == 0) begin : g_left_wrap
			assign pl = prev_wrap;
			assign cl = cur_wrap;
			assign nl = next_wrap;
		end else begin : g_left
			assign pl = prev_row[c-1];
			assign cl = cur_row[c-1];
			assign nl = next_row[c-1];
		end

		if (c == MAX_DIM - 1) begin : g_right_wrap
			assign pr = prev_row[0];
			assign cr = cur_row[0];
			assign nr = next_row[0];
		end else begin : g_right
			assign pr = (DW'(c + 1) == act_width) ? prev_row[0] : prev_row[c+1];
			assign cr = (DW'(c + 1) == act_width) ? cur_row[0] : cur_row[c+1];
			assign nr = (DW'(c + 1) == act_width) ? next_row[0] : next_row[c+1];
		end

		assign active = DW'(c) < act_width;
		assign total  = COUNT_W'(pl) + COUNT_W'(prev_row[c]) + COUNT_W'(pr)
			+ COUNT_W'(cl) + COUNT_W'(cr)
			+ COUNT_W'(nl) + COUNT_W'(next_row[c]) + COUNT_W'(nr);

		// Columns beyond the active width keep their old contents.
		assign new_alive[c] = active
			? ((total == BIRTH_COUNT) || ((total == SURVIVE_COUNT) && cur_row[c]))
			: cur_row[c];
		assign new_count[c*COUNT_W +: COUNT_W] = active
			? total : old_count[c*COUNT_W +: COUNT_W];
	end

endmodule

/* design/tlg_checker.sv */
// ----------------------------------------------------------------------------
// tlg_checker
// Port-level checks on request and result ordering of the Life grid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_alive,
	input logic [tlg_pkg::COUNT_W-1:0]  res_count
);
	import tlg_pkg::*;

	logic       req_acc;
	logic       res_acc;
	logic [1:0] pend_q;

	assign req_acc = req_valid && req_ready;
	assign res_acc = res_valid && res_ready;

	// Requests taken whose result has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_acc && !res_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (res_acc && !req_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`TLG_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`TLG_ASSERT_NXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_alive) && $stable(res_count))
	`TLG_ASSERT_IMP(a_res_has_req, clk, arst_n, res_valid, pend_q != 2'd0)
	`TLG_ASSERT_IMP(a_req_room, clk, arst_n, req_ready, pend_q <= 2'd1)

endmodule

bind toroidal_life_grid_unit tlg_checker u_tlg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_alive (result.alive_out),
	.res_count (result.neighbour_count)
);
